// File: hw/rtl/estg_pkg.sv
package estg_pkg;

   // Defaults for the top-level parameters
   localparam int SAMPLE_HZ_DEF        = 16000;
   localparam int ENVELOPE_SAMPLES_DEF = 80;
   localparam int SINE_TABLE_DEPTH_DEF = 1024;

   localparam int MS_PER_S = 1000;

   // Quarter-wave sine polynomial coefficients
   localparam logic [15:0] SIN_A = 16'd51472;
   localparam logic [15:0] SIN_B = 16'd21024;
   localparam logic [15:0] SIN_C = 16'd2320;

   localparam logic [15:0] FULL_SCALE  = 16'd32767;
   localparam logic [15:0] GAIN_RESET  = 16'd13045;
   localparam int          REL_W       = 7;
   localparam int          ENV_FRAC_W  = 16;

   // Serial divider geometry
   localparam int DIV_LEN   = 48;
   localparam int DIV_CNT_W = 6;

   // Request codes
   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_PLAY = 2'd1;
   localparam logic [1:0] REQ_STOP = 2'd2;

   // Register indexes
   localparam int         CSR_IDX_W     = 2;
   localparam logic [1:0] CSR_TONE_GAIN = 2'd0;
   localparam logic [1:0] CSR_MUTE      = 2'd1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] freq_hz;
      logic [15:0] tone_ms;
   } estg_req_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               sample_valid;
      logic               last;
      logic               busy_res;
   } estg_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] steps;
      logic [DIV_LEN-1:0]   dividend;   // left aligned
   } div_cmd_type;

   typedef struct packed {
      logic               busy;
      logic [DIV_LEN-1:0] quot;         // quotient in the low 'steps' bits
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PLAY_STEP,
      ST_PLAY_DUR,
      ST_ANGLE,
      ST_ANGLE_WAIT,
      ST_FOLD,
      ST_SIN_Z2,
      ST_SIN_T1,
      ST_SIN_T2,
      ST_SIN_Y,
      ST_GAIN,
      ST_ENV_WAIT,
      ST_MUL,
      ST_RESULT
   } estg_state_type;

endpackage

// File: hw/rtl/estg_div.sv
// Restoring divider, one quotient bit per cycle. Divisor latched at start.
module estg_div #(
   parameter int DVS_W = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  estg_pkg::div_cmd_type div_cmd,
   input  logic [DVS_W-1:0]      divisor,
   output estg_pkg::div_rsp_type div_rsp
);
   import estg_pkg::*;

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_LEN-1:0]   quot_ff, quot_in;
   logic [DVS_W:0]       trial;
   logic [DVS_W:0]       diff;
   logic                 ge;

   assign trial = {rem_ff, quot_ff[DIV_LEN-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      if (div_cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = div_cmd.steps;
         rem_in  = '0;
         dvs_in  = divisor;
         quot_in = div_cmd.dividend;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quot_in = {quot_ff[DIV_LEN-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.quot = quot_ff;

endmodule

// File: hw/rtl/enveloped_sine_tone_generator_unit.sv
// Sine tone generator with linear attack/release envelope. Each request beat
// returns exactly one response beat. A play request (re)starts or retunes a
// tone, a stop request begins the release, and a sample tick returns one
// int16 sample (sine times gain times envelope, truncated and saturated);
// the final release sample carries last. Play, stop and unused request codes,
// and ticks while idle, answer on the cycle after they are accepted. A tick
// while a tone sounds, and the work after a play answer that keeps the block
// busy, wait on the bit-serial divider, one quotient bit per cycle while it
// is busy: 23 steps for the envelope on a tick, 48 + 32 steps for the phase
// increment and the deadline on a play, and with a table depth that is not a
// power of two a further division for the table angle on a tick. The sine
// polynomial and gain products run on a shared 32x32 multiplier while the
// envelope division proceeds. Registers may be written only while the block
// is idle; csr_ready is always high.
module enveloped_sine_tone_generator_unit #(
   parameter int SAMPLE_HZ        = estg_pkg::SAMPLE_HZ_DEF,
   parameter int ENVELOPE_SAMPLES = estg_pkg::ENVELOPE_SAMPLES_DEF,
   parameter int SINE_TABLE_DEPTH = estg_pkg::SINE_TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  estg_pkg::estg_req_type         req_data,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output estg_pkg::estg_rsp_type         rsp_data,
   // register write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [estg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                    csr_data
);
   import estg_pkg::*;

   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
   localparam bit DepthPow2 = ((SINE_TABLE_DEPTH & (SINE_TABLE_DEPTH - 1)) == 0);
   localparam int DvMax = (SAMPLE_HZ > SINE_TABLE_DEPTH) ? SAMPLE_HZ : SINE_TABLE_DEPTH;
   localparam int DVS_W = $clog2(DvMax + 1);
   localparam logic [REL_W-1:0] EnvK   = REL_W'(ENVELOPE_SAMPLES);
   localparam logic [31:0]      EnvCnt = 32'(ENVELOPE_SAMPLES);

   // FSM and tone state
   estg_state_type state_ff, state_in;
   logic        playing_ff, playing_in;
   logic        releasing_ff, releasing_in;
   logic [31:0] phase_acc_ff, phase_acc_in;
   logic [31:0] phase_step_ff, phase_step_in;
   logic [31:0] sample_count_ff, sample_count_in;
   logic [31:0] stop_sample_ff, stop_sample_in;
   logic        has_deadline_ff, has_deadline_in;
   logic [REL_W-1:0] release_left_ff, release_left_in;
   logic [15:0] tone_gain_ff, tone_gain_in;
   logic        mute_ff, mute_in;
   logic        rsp_valid_ff, rsp_valid_in;
   estg_rsp_type rsp_data_ff, rsp_data_in;

   // per-sample datapath
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [31:0] u_ff, u_in;
   logic [15:0] z_ff, z_in;
   logic        sneg_ff, sneg_in;
   logic [15:0] w_ff, w_in;
   logic [15:0] t_ff, t_in;
   logic [14:0] y_ff, y_in;
   logic [30:0] a_ff, a_in;
   logic [31:0] b_ff, b_in;
   logic [16:0] mag_ff, mag_in;
   logic [REL_W-1:0] k_ff, k_in;
   logic        last_ff, last_in;
   logic [31:0] dur_prod_ff, dur_prod_in;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;

   // divider
   div_cmd_type      div_cmd;
   div_rsp_type      div_rsp;
   logic [DVS_W-1:0] dvs_sel;

   // tick control terms
   logic             out_free, req_take;
   logic             rel_start, rel_now, last_now;
   logic [REL_W-1:0] rl_cur, k_att, k_rel;
   logic [30:0]      fold;
   logic [32:0]      dl_sum;
   logic [16:0]      y_raw;
   logic [15:0]      sat_sample;
   logic [15:0]      g_eff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign prod = mul_a * mul_b;

   // Deadline is checked before the sample; release starts on that sample.
   assign rel_start = !releasing_ff && has_deadline_ff && (sample_count_ff >= stop_sample_ff);
   assign rel_now   = releasing_ff || rel_start;
   assign rl_cur    = rel_start ? EnvK : release_left_ff;
   assign last_now  = rel_now && (rl_cur <= REL_W'(1));
   // min(attack, release) taken on the numerators: both scale by the same 65536/N
   assign k_att     = (sample_count_ff < EnvCnt) ? sample_count_ff[REL_W-1:0] : EnvK;
   assign k_rel     = rel_now ? rl_cur : EnvK;

   // quarter-wave fold of the table angle
   assign fold   = u_ff[30] ? (31'h4000_0000 - {1'b0, u_ff[29:0]}) : {1'b0, u_ff[29:0]};
   assign dl_sum = {1'b0, sample_count_ff} + {1'b0, div_rsp.quot[31:0]};
   assign y_raw  = prod[31:15];
   assign g_eff  = mute_ff ? 16'd0 : tone_gain_ff;

   always_comb begin
      if (sneg_ff) begin
         sat_sample = (mag_ff >= 17'd32768) ? 16'h8000 : 16'(17'd0 - mag_ff);
      end else begin
         sat_sample = (mag_ff > {1'b0, FULL_SCALE}) ? FULL_SCALE : mag_ff[15:0];
      end
   end

   estg_div #(
      .DVS_W(DVS_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .div_cmd (div_cmd),
      .divisor (dvs_sel),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in        = state_ff;
      playing_in      = playing_ff;
      releasing_in    = releasing_ff;
      phase_acc_in    = phase_acc_ff;
      phase_step_in   = phase_step_ff;
      sample_count_in = sample_count_ff;
      stop_sample_in  = stop_sample_ff;
      has_deadline_in = has_deadline_ff;
      release_left_in = release_left_ff;
      tone_gain_in    = tone_gain_ff;
      mute_in         = mute_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;
      idx_in          = idx_ff;
      u_in            = u_ff;
      z_in            = z_ff;
      sneg_in         = sneg_ff;
      w_in            = w_ff;
      t_in            = t_ff;
      y_in            = y_ff;
      a_in            = a_ff;
      b_in            = b_ff;
      mag_in          = mag_ff;
      k_in            = k_ff;
      last_in         = last_ff;
      dur_prod_in     = dur_prod_ff;
      mul_a           = '0;
      mul_b           = '0;
      div_cmd         = '0;
      dvs_sel         = '0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_TONE_GAIN: tone_gain_in = csr_data;
            CSR_MUTE:      mute_in      = csr_data[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               // default answer: no sample, busy follows the tone
               rsp_valid_in             = 1'b1;
               rsp_data_in.sample       = '0;
               rsp_data_in.sample_valid = 1'b0;
               rsp_data_in.last         = 1'b0;
               rsp_data_in.busy_res     = playing_ff;
               unique case (req_data.req_type)
                  REQ_PLAY: begin
                     mul_a           = 32'(req_data.tone_ms);
                     mul_b           = 32'(SAMPLE_HZ);
                     dur_prod_in     = prod[31:0];
                     has_deadline_in = (req_data.tone_ms != 16'd0);
                     if (!playing_ff) begin
                        playing_in      = 1'b1;
                        releasing_in    = 1'b0;
                        release_left_in = '0;
                        phase_acc_in    = '0;
                        sample_count_in = '0;
                     end
                     div_cmd.start    = 1'b1;
                     div_cmd.steps    = DIV_CNT_W'(DIV_LEN);
                     div_cmd.dividend = {req_data.freq_hz, 32'd0};
                     dvs_sel          = DVS_W'(SAMPLE_HZ);
                     rsp_data_in.busy_res = 1'b1;
                     state_in         = ST_PLAY_STEP;
                  end
                  REQ_STOP: begin
                     if (playing_ff && !releasing_ff) begin
                        releasing_in    = 1'b1;
                        release_left_in = EnvK;
                     end
                  end
                  REQ_TICK: begin
                     if (playing_ff) begin
                        // commit control state now, datapath follows
                        rsp_valid_in    = 1'b0;
                        mul_a           = phase_acc_ff;
                        mul_b           = 32'(SINE_TABLE_DEPTH);
                        idx_in          = prod[32 +: IDX_W];
                        k_in            = (k_rel < k_att) ? k_rel : k_att;
                        last_in         = last_now;
                        phase_acc_in    = phase_acc_ff + phase_step_ff;
                        sample_count_in = (sample_count_ff == '1) ? sample_count_ff
                                                                  : sample_count_ff + 32'd1;
                        releasing_in    = rel_now;
                        release_left_in = (rl_cur != '0) ? rl_cur - REL_W'(1) : rl_cur;
                        if (last_now) begin
                           playing_in      = 1'b0;
                           releasing_in    = 1'b0;
                           release_left_in = '0;
                        end
                        state_in        = ST_ANGLE;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_PLAY_STEP: begin
            if (!div_rsp.busy) begin
               phase_step_in    = div_rsp.quot[31:0];
               div_cmd.start    = 1'b1;
               div_cmd.steps    = DIV_CNT_W'(32);
               div_cmd.dividend = {dur_prod_ff, 16'd0};
               dvs_sel          = DVS_W'(MS_PER_S);
               state_in         = ST_PLAY_DUR;
            end
         end

         ST_PLAY_DUR: begin
            if (!div_rsp.busy) begin
               stop_sample_in = dl_sum[32] ? '1 : dl_sum[31:0];
               state_in       = ST_IDLE;
            end
         end

         ST_ANGLE: begin
            if (DepthPow2) begin
               u_in     = {idx_ff, {(32 - IDX_W){1'b0}}};
               state_in = ST_FOLD;
            end else begin
               div_cmd.start    = 1'b1;
               div_cmd.steps    = DIV_CNT_W'(IDX_W + 32);
               div_cmd.dividend = {idx_ff, 32'd0, {(DIV_LEN - 32 - IDX_W){1'b0}}};
               dvs_sel          = DVS_W'(SINE_TABLE_DEPTH);
               state_in         = ST_ANGLE_WAIT;
            end
         end

         ST_ANGLE_WAIT: begin
            if (!div_rsp.busy) begin
               u_in     = div_rsp.quot[31:0];
               state_in = ST_FOLD;
            end
         end

         ST_FOLD: begin
            z_in             = fold[30:15];
            sneg_in          = u_ff[31];
            // envelope = k * 65536 / N, runs under the sine steps
            div_cmd.start    = 1'b1;
            div_cmd.steps    = DIV_CNT_W'(REL_W + ENV_FRAC_W);
            div_cmd.dividend = {k_ff, {ENV_FRAC_W{1'b0}},
                                {(DIV_LEN - REL_W - ENV_FRAC_W){1'b0}}};
            dvs_sel          = DVS_W'(ENVELOPE_SAMPLES);
            state_in         = ST_SIN_Z2;
         end

         ST_SIN_Z2: begin
            mul_a    = 32'(z_ff);
            mul_b    = 32'(z_ff);
            w_in     = prod[30:15];
            state_in = ST_SIN_T1;
         end

         ST_SIN_T1: begin
            mul_a    = 32'(SIN_C);
            mul_b    = 32'(w_ff);
            t_in     = SIN_B - prod[30:15];
            state_in = ST_SIN_T2;
         end

         ST_SIN_T2: begin
            mul_a    = 32'(t_ff);
            mul_b    = 32'(w_ff);
            t_in     = SIN_A - prod[30:15];
            state_in = ST_SIN_Y;
         end

         ST_SIN_Y: begin
            mul_a    = 32'(t_ff);
            mul_b    = 32'(z_ff);
            y_in     = (y_raw > {1'b0, FULL_SCALE}) ? FULL_SCALE[14:0] : y_raw[14:0];
            state_in = ST_GAIN;
         end

         ST_GAIN: begin
            mul_a    = 32'(y_ff);
            mul_b    = 32'(g_eff);
            a_in     = prod[30:0];
            state_in = ST_ENV_WAIT;
         end

         ST_ENV_WAIT: begin
            if (!div_rsp.busy) begin
               mul_a    = 32'(div_rsp.quot[ENV_FRAC_W:0]);
               mul_b    = 32'(FULL_SCALE);
               b_in     = prod[31:0];
               state_in = ST_MUL;
            end
         end

         ST_MUL: begin
            mul_a    = 32'(a_ff);
            mul_b    = b_ff;
            mag_in   = prod[62:46];
            state_in = ST_RESULT;
         end

         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.sample       = sat_sample;
               rsp_data_in.sample_valid = 1'b1;
               rsp_data_in.last         = last_ff;
               rsp_data_in.busy_res     = 1'b1;
               state_in                 = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         playing_ff      <= 1'b0;
         releasing_ff    <= 1'b0;
         phase_acc_ff    <= '0;
         phase_step_ff   <= '0;
         sample_count_ff <= '0;
         stop_sample_ff  <= '0;
         has_deadline_ff <= 1'b0;
         release_left_ff <= '0;
         tone_gain_ff    <= GAIN_RESET;
         mute_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         playing_ff      <= playing_in;
         releasing_ff    <= releasing_in;
         phase_acc_ff    <= phase_acc_in;
         phase_step_ff   <= phase_step_in;
         sample_count_ff <= sample_count_in;
         stop_sample_ff  <= stop_sample_in;
         has_deadline_ff <= has_deadline_in;
         release_left_ff <= release_left_in;
         tone_gain_ff    <= tone_gain_in;
         mute_ff         <= mute_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      idx_ff      <= idx_in;
      u_ff        <= u_in;
      z_ff        <= z_in;
      sneg_ff     <= sneg_in;
      w_ff        <= w_in;
      t_ff        <= t_in;
      y_ff        <= y_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      mag_ff      <= mag_in;
      k_ff        <= k_in;
      last_ff     <= last_in;
      dur_prod_ff <= dur_prod_in;
   end

endmodule
